### sv/mbf_pkg.sv
// Shared types, codes and the CRC-16 byte update for the master framer.
// No dependencies; imported by every module of the block.
package mbf_pkg;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DATA  = 2'd1;
  localparam logic [1:0] MODE_RESP  = 2'd2;

  localparam logic [1:0] KIND_REQ     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [1:0] VRD_OK    = 2'd0;
  localparam logic [1:0] VRD_SHORT = 2'd1;
  localparam logic [1:0] VRD_CRC   = 2'd2;
  localparam logic [1:0] VRD_EXC   = 2'd3;

  localparam logic [1:0] OP_READ_RAM   = 2'd0;
  localparam logic [1:0] OP_WRITE_RAM  = 2'd1;
  localparam logic [1:0] OP_READ_EEP   = 2'd2;
  localparam logic [1:0] OP_WRITE_EEP  = 2'd3;

  localparam logic [7:0] FC_READ_RAM  = 8'h44;
  localparam logic [7:0] FC_WRITE_RAM = 8'h41;
  localparam logic [7:0] FC_READ_EEP  = 8'h46;
  localparam logic [7:0] FC_WRITE_EEP = 8'h43;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  STATION_RESET = 8'hFE;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  localparam logic [8:0] RX_INDEX_MAX = 9'd511;
  localparam logic [9:0] RX_MIN_LEN   = 10'd4;

  localparam int unsigned REQ_BYTES = 5;

  typedef struct packed {
    logic [2:0]                nreq;
    logic [REQ_BYTES-1:0][7:0] req;
    logic                      crc_init;
    logic                      crc;
    logic                      pay;
    logic [7:0]                pay_byte;
    logic                      vrd;
    logic [1:0]                verdict;
    logic [7:0]                exc;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] func_code(input logic [1:0] op);
    logic [7:0] f;
    case (op)
      OP_READ_RAM:  f = FC_READ_RAM;
      OP_WRITE_RAM: f = FC_WRITE_RAM;
      OP_READ_EEP:  f = FC_READ_EEP;
      OP_WRITE_EEP: f = FC_WRITE_EEP;
      default:      f = FC_READ_RAM;
    endcase
    return f;
  endfunction

endpackage

### sv/mbf_front.sv
// Front end: accepts items, tracks request and response state, builds commands.
// Depends on mbf_pkg; feeds mbf_queue.
module mbf_front import mbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_target_address,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_data_byte,
  input  logic        in_response_last,
  input  logic        q_full,
  output logic        push,
  output cmd_t        cmd
);

  logic [7:0]  station_r, station_nxt;
  logic [7:0]  tx_left_r, tx_left_nxt;
  logic        is_read_r, is_read_nxt;
  logic [15:0] rx_crc_r, rx_crc_nxt;
  logic [8:0]  rx_idx_r, rx_idx_nxt;
  logic [7:0]  rx_fn_r, rx_fn_nxt;
  logic [7:0]  rx_exc_r, rx_exc_nxt;
  logic [7:0]  hold0_r, hold0_nxt;
  logic [7:0]  hold1_r, hold1_nxt;
  logic [15:0] rx_crc_upd;
  logic        acc;
  logic        start_crc;

  assign in_ready   = !q_full;
  assign acc        = in_valid && in_ready;
  assign rx_crc_upd = crc_feed(rx_crc_r, in_data_byte);
  assign start_crc  = !in_operation[0] || (in_byte_count == 8'd0);

  always_comb begin
    station_nxt = cfg_we ? cfg_wdata : station_r;
    tx_left_nxt = tx_left_r;
    is_read_nxt = is_read_r;
    rx_crc_nxt  = rx_crc_r;
    rx_idx_nxt  = rx_idx_r;
    rx_fn_nxt   = rx_fn_r;
    rx_exc_nxt  = rx_exc_r;
    hold0_nxt   = hold0_r;
    hold1_nxt   = hold1_r;
    cmd         = '0;
    push        = 1'b0;
    if (acc) begin
      case (in_mode)
        MODE_START: begin
          is_read_nxt  = !in_operation[0];
          rx_crc_nxt   = CRC_INIT;
          rx_idx_nxt   = '0;
          rx_fn_nxt    = '0;
          rx_exc_nxt   = '0;
          hold0_nxt    = '0;
          hold1_nxt    = '0;
          cmd.nreq     = 3'(REQ_BYTES);
          cmd.req[0]   = station_r;
          cmd.req[1]   = func_code(in_operation);
          cmd.req[2]   = in_target_address[15:8];
          cmd.req[3]   = in_target_address[7:0];
          cmd.req[4]   = in_byte_count;
          cmd.crc_init = 1'b1;
          cmd.crc      = start_crc;
          tx_left_nxt  = start_crc ? 8'd0 : in_byte_count;
          push         = 1'b1;
        end
        MODE_DATA: begin
          if (tx_left_r != 8'd0) begin
            cmd.nreq    = 3'd1;
            cmd.req[0]  = in_data_byte;
            cmd.crc     = (tx_left_r == 8'd1);
            tx_left_nxt = tx_left_r - 8'd1;
            push        = 1'b1;
          end
        end
        MODE_RESP: begin
          rx_crc_nxt = rx_crc_upd;
          if (rx_idx_r == 9'd1) begin
            rx_fn_nxt = in_data_byte;
          end else if (rx_idx_r == 9'd2) begin
            rx_exc_nxt = in_data_byte;
          end
          if (rx_idx_r >= 9'd3) begin
            if (rx_idx_r >= 9'd5 && is_read_r && ((rx_fn_r & EXC_FLAG) == 8'h00)) begin
              cmd.pay      = 1'b1;
              cmd.pay_byte = hold0_r;
            end
            hold0_nxt = hold1_r;
            hold1_nxt = in_data_byte;
          end
          if (rx_idx_r != RX_INDEX_MAX) begin
            rx_idx_nxt = rx_idx_r + 9'd1;
          end
          if (in_response_last) begin
            cmd.vrd = 1'b1;
            if (({1'b0, rx_idx_r} + 10'd1) < RX_MIN_LEN) begin
              cmd.verdict = VRD_SHORT;
            end else if (rx_crc_upd != 16'h0000) begin
              cmd.verdict = VRD_CRC;
            end else if ((rx_fn_r & EXC_FLAG) != 8'h00) begin
              cmd.verdict = VRD_EXC;
              cmd.exc     = rx_exc_r;
            end else begin
              cmd.verdict = VRD_OK;
            end
            rx_crc_nxt = CRC_INIT;
            rx_idx_nxt = '0;
            rx_fn_nxt  = '0;
            rx_exc_nxt = '0;
            hold0_nxt  = '0;
            hold1_nxt  = '0;
          end
          push = cmd.pay || cmd.vrd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= STATION_RESET;
      tx_left_r <= '0;
      is_read_r <= 1'b0;
      rx_crc_r  <= CRC_INIT;
      rx_idx_r  <= '0;
      rx_fn_r   <= '0;
      rx_exc_r  <= '0;
      hold0_r   <= '0;
      hold1_r   <= '0;
    end else begin
      station_r <= station_nxt;
      tx_left_r <= tx_left_nxt;
      is_read_r <= is_read_nxt;
      rx_crc_r  <= rx_crc_nxt;
      rx_idx_r  <= rx_idx_nxt;
      rx_fn_r   <= rx_fn_nxt;
      rx_exc_r  <= rx_exc_nxt;
      hold0_r   <= hold0_nxt;
      hold1_r   <= hold1_nxt;
    end
  end

endmodule

### sv/mbf_queue.sv
// Command queue between front end and back end.
// Depends on mbf_pkg for cmd_t.
module mbf_queue import mbf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == CNT_W'(0));
  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign head    = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### sv/mbf_back.sv
// Back end: expands queued commands into result transactions, one per cycle when
// out_ready allows, and runs the transmit CRC. Depends on mbf_pkg; drains mbf_queue.
module mbf_back import mbf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_verdict,
  output logic [7:0] out_exception_code,
  output logic       out_last
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_REQ   = 3'd1;
  localparam logic [2:0] PH_CRCL  = 3'd2;
  localparam logic [2:0] PH_CRCH  = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;
  localparam logic [2:0] PH_VRD   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  function automatic logic [2:0] next_phase(input cmd_t c, input logic [2:0] cur);
    logic [2:0] n;
    if (cur < PH_REQ && c.nreq != 3'd0) begin
      n = PH_REQ;
    end else if (cur < PH_CRCL && c.crc) begin
      n = PH_CRCL;
    end else if (cur < PH_CRCH && c.crc) begin
      n = PH_CRCH;
    end else if (cur < PH_PAY && c.pay) begin
      n = PH_PAY;
    end else if (cur < PH_VRD && c.vrd) begin
      n = PH_VRD;
    end else begin
      n = PH_DONE;
    end
    return n;
  endfunction

  logic [2:0]  ph_r, ph_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  verdict_r, verdict_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic        last_r, last_nxt;
  logic [2:0]  eff_ph, nph;
  logic [15:0] crc_base;
  logic [7:0]  req_byte;
  logic        load;

  assign load     = !q_empty && (!out_valid_r || out_ready);
  assign eff_ph   = (ph_r == PH_START) ? next_phase(head, PH_START) : ph_r;
  assign crc_base = (head.crc_init && idx_r == 3'd0) ? CRC_INIT : crc_r;
  assign req_byte = head.req[idx_r];

  always_comb begin
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    verdict_nxt   = verdict_r;
    exc_nxt       = exc_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    nph           = PH_DONE;
    if (load) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_REQ;
      byte_nxt      = 8'h00;
      verdict_nxt   = VRD_OK;
      exc_nxt       = 8'h00;
      case (eff_ph)
        PH_REQ: begin
          byte_nxt = req_byte;
          crc_nxt  = crc_feed(crc_base, req_byte);
          if ((idx_r + 3'd1) < head.nreq) begin
            nph     = PH_REQ;
            idx_nxt = idx_r + 3'd1;
          end else begin
            nph     = next_phase(head, PH_REQ);
            idx_nxt = '0;
          end
        end
        PH_CRCL: begin
          byte_nxt = crc_r[7:0];
          nph      = next_phase(head, PH_CRCL);
        end
        PH_CRCH: begin
          byte_nxt = crc_r[15:8];
          nph      = next_phase(head, PH_CRCH);
        end
        PH_PAY: begin
          kind_nxt = KIND_PAYLOAD;
          byte_nxt = head.pay_byte;
          nph      = next_phase(head, PH_PAY);
        end
        PH_VRD: begin
          kind_nxt    = KIND_VERDICT;
          verdict_nxt = head.verdict;
          exc_nxt     = head.exc;
          nph         = next_phase(head, PH_VRD);
        end
        default: begin
          nph = PH_DONE;
        end
      endcase
      if (nph == PH_DONE) begin
        pop      = 1'b1;
        ph_nxt   = PH_START;
        idx_nxt  = '0;
        last_nxt = 1'b1;
      end else begin
        ph_nxt   = nph;
        last_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_START;
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    verdict_r <= verdict_nxt;
    exc_r     <= exc_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_byte           = byte_r;
  assign out_verdict        = verdict_r;
  assign out_exception_code = exc_r;
  assign out_last           = last_r;

endmodule

### sv/modbus_style_master_framer.sv
// Top level of the master-side framer: front end, command queue, back end.
// Depends on mbf_pkg, mbf_front, mbf_queue and mbf_back.
//
// Input channel (in_valid/in_ready) takes one item per cycle while the
// command queue has room. A start item yields the station byte, function
// code, address high/low and count, then the CRC low/high bytes for reads
// and zero-length writes (7 transactions). A write data byte yields one
// request byte, plus the CRC bytes after the last one. A response byte
// yields up to one read payload byte and, on the marked last byte, a verdict.
// Ignored items yield nothing. out_last flags the final transaction of an item.
// An accepted item is first written into the command queue; its results then
// leave through the back end's output register. Throughput: the back end issues
// one result transaction per cycle while out_ready is high.
// When out_ready is low the output register holds, the queue fills, and
// in_ready drops once QUEUE_DEPTH commands are waiting.
// Reset (rst_n low, synchronous): station address 0xFE, both CRCs 0xFFFF,
// receive side restarted, queue emptied, no transaction pending.
// cfg_we writes the station address at once; write it only while idle.
module modbus_style_master_framer import mbf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_target_address,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_data_byte,
  input  logic        in_response_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_verdict,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);

  cmd_t cmd, head;
  logic push, pop, q_empty, q_full;

  mbf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_operation      (in_operation),
    .in_target_address (in_target_address),
    .in_byte_count     (in_byte_count),
    .in_data_byte      (in_data_byte),
    .in_response_last  (in_response_last),
    .q_full            (q_full),
    .push              (push),
    .cmd               (cmd)
  );

  mbf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  mbf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_empty            (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_verdict        (out_verdict),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_VERDICT) |-> (out_byte == 8'h00 && out_last))
    else $error("verdict carries a byte or is not last");

  a_data_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_REQ || out_kind == KIND_PAYLOAD))
      |-> (out_verdict == VRD_OK && out_exception_code == 8'h00))
    else $error("data transaction carries verdict fields");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_REQ || out_kind == KIND_PAYLOAD ||
                   out_kind == KIND_VERDICT))
    else $error("illegal result kind");

endmodule

### verif/tb_modbus_style_master_framer.sv
// Self-checking testbench for modbus_style_master_framer: request framing, write data,
// response verdicts and read payload forwarding, each checked against an in-bench model.
// Depends on mbf_pkg and the RTL of the framer; no files, no arguments.
module tb_modbus_style_master_framer;
  timeunit 1ns;
  timeprecision 1ps;
  import mbf_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  operation;
    logic [15:0] target_address;
    logic [7:0]  byte_count;
    logic [7:0]  data_byte;
    logic        response_last;
  } link_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] verdict;
    logic [7:0] exc_code;
    logic       last;
  } framer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = 2'd0;
  logic [1:0]  in_operation = 2'd0;
  logic [15:0] in_target_address = 16'h0000;
  logic [7:0]  in_byte_count = 8'h00;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_response_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  out_verdict;
  logic [7:0]  out_exception_code;
  logic        out_last;

  // model state
  logic [7:0]  station = STATION_RESET;
  logic [15:0] tx_crc = CRC_INIT;
  logic [15:0] rx_crc = CRC_INIT;
  logic [7:0]  tx_left = 8'h00;
  logic        req_is_read = 1'b0;
  logic [8:0]  rx_idx = 9'd0;
  logic [7:0]  rx_func = 8'h00;
  logic [7:0]  rx_exc = 8'h00;
  logic [7:0]  hold0 = 8'h00;
  logic [7:0]  hold1 = 8'h00;

  framer_result_t results_due[$];
  logic [7:0]     reply_frame[$];
  framer_result_t seen;
  framer_result_t due;

  int err_count = 0;
  int items_done = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  modbus_style_master_framer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_operation       (in_operation),
    .in_target_address  (in_target_address),
    .in_byte_count      (in_byte_count),
    .in_data_byte       (in_data_byte),
    .in_response_last   (in_response_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_byte           (out_byte),
    .out_verdict        (out_verdict),
    .out_exception_code (out_exception_code),
    .out_last           (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= stall_pct);
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] op_code(input logic [1:0] op);
    case (op)
      OP_WRITE_RAM: return FC_WRITE_RAM;
      OP_READ_EEP:  return FC_READ_EEP;
      OP_WRITE_EEP: return FC_WRITE_EEP;
      default:      return FC_READ_RAM;
    endcase
  endfunction

  function automatic link_item_t random_item();
    link_item_t it;
    it.mode           = 2'($urandom_range(3));
    it.operation      = 2'($urandom_range(3));
    it.target_address = 16'($urandom);
    it.byte_count     = 8'($urandom);
    it.data_byte      = 8'($urandom);
    it.response_last  = 1'($urandom);
    return it;
  endfunction

  task automatic note_error(input string msg);
    $display("tb_modbus_style_master_framer: mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] value,
                             input logic [1:0] verdict, input logic [7:0] exc_code);
    framer_result_t r;
    r.kind     = kind;
    r.value    = value;
    r.verdict  = verdict;
    r.exc_code = exc_code;
    r.last     = 1'b0;
    results_due.insert(results_due.size(), r);
  endtask

  task automatic add_reply_byte(input logic [7:0] b);
    reply_frame.insert(reply_frame.size(), b);
  endtask

  task automatic push_tx(input logic [7:0] b);
    tx_crc = crc16_step(tx_crc, b);
    push_result(KIND_REQ, b, VRD_OK, 8'h00);
  endtask

  task automatic push_tx_crc();
    push_result(KIND_REQ, tx_crc[7:0], VRD_OK, 8'h00);
    push_result(KIND_REQ, tx_crc[15:8], VRD_OK, 8'h00);
  endtask

  task automatic restart_rx();
    rx_crc  = CRC_INIT;
    rx_idx  = 9'd0;
    rx_func = 8'h00;
    rx_exc  = 8'h00;
    hold0   = 8'h00;
    hold1   = 8'h00;
  endtask

  task automatic frame_item(input link_item_t it, output bit took);
    int         n0;
    logic [8:0] idx;
    logic [1:0] v;
    logic [7:0] x;
    n0 = results_due.size();
    took = 1'b1;
    case (it.mode)
      MODE_START: begin
        tx_crc = CRC_INIT;
        req_is_read = !it.operation[0];
        restart_rx();
        push_tx(station);
        push_tx(op_code(it.operation));
        push_tx(it.target_address[15:8]);
        push_tx(it.target_address[7:0]);
        push_tx(it.byte_count);
        if (req_is_read || it.byte_count == 8'h00) begin
          tx_left = 8'h00;
          push_tx_crc();
        end else begin
          tx_left = it.byte_count;
        end
      end
      MODE_DATA: begin
        if (tx_left != 8'h00) begin
          push_tx(it.data_byte);
          tx_left--;
          if (tx_left == 8'h00) push_tx_crc();
        end else begin
          took = 1'b0;
        end
      end
      MODE_RESP: begin
        idx = rx_idx;
        rx_crc = crc16_step(rx_crc, it.data_byte);
        if (idx == 9'd1) rx_func = it.data_byte;
        else if (idx == 9'd2) rx_exc = it.data_byte;
        if (idx >= 9'd3) begin
          if (idx >= 9'd5 && req_is_read && (rx_func & EXC_FLAG) == 8'h00) begin
            push_result(KIND_PAYLOAD, hold0, VRD_OK, 8'h00);
          end
          hold0 = hold1;
          hold1 = it.data_byte;
        end
        if (rx_idx != RX_INDEX_MAX) rx_idx++;
        if (it.response_last) begin
          x = 8'h00;
          if (idx < 9'd3) begin
            v = VRD_SHORT;
          end else if (rx_crc != 16'h0000) begin
            v = VRD_CRC;
          end else if ((rx_func & EXC_FLAG) != 8'h00) begin
            v = VRD_EXC;
            x = rx_exc;
          end else begin
            v = VRD_OK;
          end
          push_result(KIND_VERDICT, 8'h00, v, x);
          restart_rx();
        end
      end
      default: begin
        took = 1'b0;
      end
    endcase
    if (results_due.size() > n0) results_due[results_due.size() - 1].last = 1'b1;
  endtask

  task automatic send_item(input link_item_t it);
    bit acc;
    bit took;
    if (int'($urandom_range(99)) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (int'($urandom_range(99)) < gap_pct);
    end
    in_valid          <= 1'b1;
    in_mode           <= it.mode;
    in_operation      <= it.operation;
    in_target_address <= it.target_address;
    in_byte_count     <= it.byte_count;
    in_data_byte      <= it.data_byte;
    in_response_last  <= it.response_last;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end
    frame_item(it, took);
    if (took) items_done++;
  endtask

  task automatic send_start(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] count);
    link_item_t it;
    it = random_item();
    it.mode = MODE_START;
    it.operation = op;
    it.target_address = addr;
    it.byte_count = count;
    send_item(it);
  endtask

  task automatic send_data(input logic [1:0] mode, input logic [7:0] b);
    link_item_t it;
    it = random_item();
    it.mode = mode;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic build_reply(input logic [7:0] fc, input logic [7:0] third, input int npay);
    logic [15:0] c;
    reply_frame.delete();
    add_reply_byte(station);
    add_reply_byte(fc);
    add_reply_byte(third);
    repeat (npay) add_reply_byte(8'($urandom));
    c = CRC_INIT;
    foreach (reply_frame[i]) c = crc16_step(c, reply_frame[i]);
    add_reply_byte(c[7:0]);
    add_reply_byte(c[15:8]);
  endtask

  task automatic trim_reply(input int keep);
    while (reply_frame.size() > keep) void'(reply_frame.pop_back());
  endtask

  task automatic send_reply();
    link_item_t it;
    foreach (reply_frame[i]) begin
      it = random_item();
      it.mode = MODE_RESP;
      it.data_byte = reply_frame[i];
      it.response_last = (i == reply_frame.size() - 1);
      send_item(it);
    end
  endtask

  // drop valid, wait for every result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_station(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    station = v;
  endtask

  task automatic run_exchange(input bit whole);
    link_item_t it;
    int         cnt;
    int         sent;
    int         pick;
    logic [7:0] fc;
    it = random_item();
    it.mode = MODE_START;
    if (it.operation[0]) begin
      it.byte_count = ($urandom_range(39) == 0) ? 8'($urandom) : 8'($urandom_range(6));
    end
    send_item(it);
    cnt  = it.operation[0] ? int'(it.byte_count) : 0;
    sent = whole ? cnt : int'($urandom_range(cnt));
    repeat (sent) send_data(MODE_DATA, 8'($urandom));
    if (!whole && $urandom_range(1) == 0) return;
    fc = op_code(it.operation);
    pick = $urandom_range(9);
    if (pick < 5) begin
      build_reply(fc, 8'($urandom), $urandom_range(10));
    end else if (pick < 7) begin
      build_reply(fc | EXC_FLAG, 8'($urandom), 0);
    end else if (pick == 7) begin
      build_reply(fc, 8'($urandom), $urandom_range(6));
      reply_frame[$urandom_range(reply_frame.size() - 1)] ^= 8'(1 << $urandom_range(7));
    end else if (pick == 8) begin
      build_reply(fc, 8'($urandom), 0);
      trim_reply($urandom_range(1, 3));
    end else begin
      reply_frame.delete();
      repeat ($urandom_range(4, 8)) add_reply_byte(8'($urandom));
    end
    if (!whole) trim_reply($urandom_range(1, reply_frame.size()));
    send_reply();
  endtask

  task automatic test_request_frames();
    send_start(OP_READ_RAM, 16'h0000, 8'h00);
    send_start(OP_WRITE_RAM, 16'hFFFF, 8'h00);
    send_start(OP_READ_EEP, 16'h5AA5, 8'hFF);
    settle();
  endtask

  task automatic test_write_data();
    send_start(OP_WRITE_EEP, 16'h1234, 8'h02);
    send_data(MODE_DATA, 8'h00);
    send_data(MODE_DATA, 8'hFF);
    send_data(MODE_DATA, 8'h5A);
    send_data(MODE_IGNORED, 8'hFF);
    send_start(OP_WRITE_RAM, 16'($urandom), 8'h03);
    send_data(MODE_DATA, 8'($urandom));
    send_start(OP_READ_RAM, 16'($urandom), 8'h04);
  endtask

  task automatic test_response_verdicts();
    // hold the sender until every queued result has drained
    settle();
    build_reply(FC_READ_RAM, 8'h01, 0);
    trim_reply(2);
    send_reply();
    build_reply(FC_READ_RAM, 8'h01, 0);
    reply_frame[4] ^= 8'h01;
    send_reply();
    build_reply(FC_READ_RAM | EXC_FLAG, 8'h02, 0);
    send_reply();
    build_reply(FC_READ_RAM, 8'h01, 1);
    send_reply();
    settle();
  endtask

  task automatic test_long_response();
    send_start(OP_READ_EEP, 16'($urandom), 8'($urandom));
    build_reply(FC_READ_EEP, 8'($urandom), 30);
    send_reply();
    settle();
  endtask

  task automatic test_random_traffic(input int n_items, input int gap, input int stall);
    int first;
    int pick;
    gap_pct = gap;
    stall_pct = stall;
    first = items_done;
    while (items_done - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) run_exchange(1'b1);
      else if (pick < 85) send_item(random_item());
      else run_exchange(1'b0);
    end
    settle();
    gap_pct = 0;
    stall_pct = 0;
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.kind     = out_kind;
      seen.value    = out_byte;
      seen.verdict  = out_verdict;
      seen.exc_code = out_exception_code;
      seen.last     = out_last;
      if (results_due.size() == 0) begin
        note_error($sformatf("result with nothing due: kind %0d byte %02h verdict %0d",
                             out_kind, out_byte, out_verdict));
      end else begin
        due = results_due.pop_front();
        if (seen !== due) begin
          note_error($sformatf({"kind %0d/%0d byte %02h/%02h verdict %0d/%0d",
                                " exc %02h/%02h last %0b/%0b"},
                               seen.kind, due.kind, seen.value, due.value,
                               seen.verdict, due.verdict, seen.exc_code, due.exc_code,
                               seen.last, due.last));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_frames();
    set_station(8'h00);
    test_write_data();
    test_response_verdicts();
    set_station(8'hFF);
    test_long_response();
    set_station(8'($urandom));
    test_random_traffic(75, 0, 0);
    set_station(8'($urandom));
    test_random_traffic(75, 61, 0);
    set_station(8'($urandom));
    test_random_traffic(75, 0, 61);
    set_station(8'($urandom));
    test_random_traffic(75, 23, 23);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("tb_modbus_style_master_framer: clean");
    end else begin
      $display("tb_modbus_style_master_framer: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_modbus_style_master_framer: errors");
    $finish;
  end

endmodule
